### design/ppad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppad_pkg
// Shared types, constants and the angle pattern tables of the pad decoder.
// ----------------------------------------------------------------------------
package ppad_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ANGLE_W          = 10;
  localparam int NROWS            = 12;
  localparam int NPASS            = 5;
  localparam int ROW_W            = 4;

  typedef enum logic [1:0] {
    CLS_N = 2'd0,
    CLS_Q = 2'd1,
    CLS_H = 2'd2,
    CLS_Z = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SIMPLE  = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SRCH,
    ST_NUM,
    ST_DA_GO,
    ST_DA_WAIT,
    ST_DB_GO,
    ST_DB_WAIT,
    ST_EMIT,
    ST_NONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic pass_adv;
    logic store_simple;
    logic latch_row;
    logic calc_num;
    logic div_start_a;
    logic div_start_b;
    logic latch_qa;
    logic store_cplx;
    logic emit_step;
    logic out_valid;
    logic out_none;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic pass_first;
    logic pass_last;
    logic hit_s;
    logic hit_c;
    logic cnt_zero;
    logic div_done;
    logic idx_last;
  } stat_t;

  function automatic logic [7:0] pcode(cls_t a, cls_t b, cls_t c, cls_t d);
    return {a, b, c, d};
  endfunction

  localparam logic [7:0] WHOLE_CODE [NROWS] = '{
    pcode(CLS_H, CLS_Q, CLS_Q, CLS_Z), pcode(CLS_Q, CLS_Q, CLS_H, CLS_Z),
    pcode(CLS_Z, CLS_H, CLS_H, CLS_Z), pcode(CLS_Z, CLS_H, CLS_Q, CLS_Q),
    pcode(CLS_Z, CLS_Q, CLS_Q, CLS_H), pcode(CLS_Z, CLS_Z, CLS_H, CLS_H),
    pcode(CLS_Q, CLS_Z, CLS_H, CLS_Q), pcode(CLS_H, CLS_Z, CLS_Q, CLS_Q),
    pcode(CLS_H, CLS_Z, CLS_Z, CLS_H), pcode(CLS_Q, CLS_Q, CLS_Z, CLS_H),
    pcode(CLS_Q, CLS_H, CLS_Z, CLS_Q), pcode(CLS_H, CLS_H, CLS_Z, CLS_Z)
  };

  localparam logic [7:0] SPLIT_CODE [NROWS] = '{
    pcode(CLS_N, CLS_Q, CLS_N, CLS_Z), pcode(CLS_N, CLS_N, CLS_H, CLS_Z),
    pcode(CLS_Z, CLS_H, CLS_N, CLS_N), pcode(CLS_Z, CLS_N, CLS_Q, CLS_N),
    pcode(CLS_Z, CLS_N, CLS_N, CLS_H), pcode(CLS_N, CLS_Z, CLS_H, CLS_N),
    pcode(CLS_N, CLS_Z, CLS_N, CLS_Q), pcode(CLS_H, CLS_Z, CLS_N, CLS_N),
    pcode(CLS_N, CLS_N, CLS_Z, CLS_H), pcode(CLS_Q, CLS_N, CLS_Z, CLS_N),
    pcode(CLS_N, CLS_H, CLS_Z, CLS_N), pcode(CLS_H, CLS_N, CLS_N, CLS_Z)
  };

  localparam logic [3:0] STEP [NROWS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11
  };

  localparam logic [1:0] PAD_ONE [NROWS] = '{
    2'd2, 2'd1, 2'd3, 2'd3, 2'd2, 2'd0, 2'd0, 2'd3, 2'd1, 2'd1, 2'd0, 2'd2
  };

  localparam logic signed [4:0] K_ONE [NROWS] = '{
    -5'sd1, 5'sd0, 5'sd2, 5'sd2, 5'sd3, 5'sd5, 5'sd5, 5'sd6, 5'sd8, 5'sd8, 5'sd9, 5'sd11
  };

  localparam logic [1:0] PAD_TWO [NROWS] = '{
    2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd0, 2'd3, 2'd3, 2'd1
  };

  localparam logic signed [4:0] K_TWO [NROWS] = '{
    5'sd2, 5'sd2, 5'sd4, 5'sd5, 5'sd5, 5'sd7, 5'sd8, 5'sd8, 5'sd10, 5'sd11, 5'sd11, 5'sd13
  };

endpackage

`default_nettype wire

### design/ppad_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppad_div
// Restoring divider, one quotient bit per cycle, signed numerator,
// quotient truncated toward zero. Quotient magnitude must fit ANGLE_W bits.
// ----------------------------------------------------------------------------
module ppad_div import ppad_pkg::*; #(
  parameter int NW = 28,
  parameter int DW = 18
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [NW-1:0]        num,
  input  wire logic [DW-1:0]               den,
  output logic                             done,
  output logic signed [ANGLE_W-1:0]        quo
);

  localparam int CW  = (NW > DW + ANGLE_W) ? NW : DW + ANGLE_W;
  localparam int SCW = $clog2(ANGLE_W);

  logic [NW-1:0]          rem;
  logic [DW+ANGLE_W-1:0]  dsh;
  logic [ANGLE_W-1:0]     q;
  logic [SCW-1:0]         step;
  logic                   run;
  logic                   neg;
  logic [NW-1:0]          num_abs;
  logic                   fits;
  logic [CW-1:0]          diff;

  assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
  assign fits    = CW'(rem) >= CW'(dsh);
  assign diff    = CW'(rem) - CW'(dsh);
  assign quo     = neg ? ANGLE_W'(-$signed(q)) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && step == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // first trial subtracts den << (ANGLE_W-1), last one den itself
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num_abs;
      neg  <= num[NW-1];
      dsh  <= {1'b0, den, {(ANGLE_W-1){1'b0}}};
      step <= SCW'(ANGLE_W - 1);
      q    <= '0;
    end else if (run) begin
      if (fits) begin
        rem <= NW'(diff);
      end
      q    <= {q[ANGLE_W-2:0], fits};
      dsh  <= dsh >> 1;
      step <= step - 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/ppad_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppad_dp
// Datapath: pad normalization, per-pass classification and table lookup,
// numerator build, divider, hit buffer and result registers.
// ----------------------------------------------------------------------------
module ppad_dp import ppad_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cmd_t                      cmd,
  output stat_t                          stat,
  input  wire logic [SAMPLE_WIDTH-1:0]   pad_a,
  input  wire logic [SAMPLE_WIDTH-1:0]   pad_b,
  input  wire logic [SAMPLE_WIDTH-1:0]   pad_c,
  input  wire logic [SAMPLE_WIDTH-1:0]   pad_d,
  output logic                           result_valid,
  output logic [1:0]                     match_kind,
  output logic signed [ANGLE_W-1:0]      angle_first,
  output logic signed [ANGLE_W-1:0]      angle_second,
  output logic [ANGLE_W-1:0]             spread,
  output logic [14:0]                    margin_used,
  output logic [2:0]                     loose_pad,
  output logic                           last
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int TW  = SW + 2;   // sum of four pads
  localparam int MW  = SW - 1;   // margin, below total/8
  localparam int SNW = SW + 7;   // 4*v + k*total
  localparam int NW  = SW + 12;  // times 30

  logic [SW-1:0]  raw [4];
  logic [SW-1:0]  v   [4];
  logic [TW-1:0]  total;
  logic [MW-1:0]  margin;
  logic [2:0]     pass;
  logic [2:0]     cnt;
  logic [2:0]     idx;
  logic [ROW_W-1:0] row;
  logic signed [NW-1:0] numa, numb;
  logic signed [ANGLE_W-1:0] qa;

  logic [1:0]                 bk_kind [NPASS];
  logic signed [ANGLE_W-1:0]  bk_a    [NPASS];
  logic signed [ANGLE_W-1:0]  bk_b    [NPASS];
  logic [2:0]                 bk_pass [NPASS];

  // normalization
  logic [SW-1:0] lo01, lo23, lo;
  assign lo01 = (raw[1] < raw[0]) ? raw[1] : raw[0];
  assign lo23 = (raw[3] < raw[2]) ? raw[3] : raw[2];
  assign lo   = (lo23 < lo01) ? lo23 : lo01;

  logic [TW-1:0] half, quarter;
  logic [MW-1:0] limit;
  assign half    = total >> 1;
  assign quarter = total >> 2;
  assign limit   = MW'(total >> 3);

  // classification of the current pass
  logic [7:0] code;
  logic [2:0] ncnt;
  always_comb begin
    logic [TW-1:0] tol;
    logic [TW-1:0] vv;
    logic [TW-1:0] dq;
    logic [TW-1:0] dh;
    cls_t c;
    code = '0;
    ncnt = '0;
    for (int i = 0; i < 4; i++) begin
      tol = TW'(margin) + TW'(pass == 3'(i + 1));
      vv  = TW'(v[i]);
      dq  = (vv >= quarter) ? vv - quarter : quarter - vv;
      dh  = (vv >= half) ? vv - half : half - vv;
      if (vv < tol) begin
        c = CLS_Z;
      end else if (dq < tol) begin
        c = CLS_Q;
      end else if (dh < tol) begin
        c = CLS_H;
      end else begin
        c = CLS_N;
        ncnt = ncnt + 1'b1;
      end
      code = {code[5:0], c};
    end
  end

  logic             wfound, sfound;
  logic [ROW_W-1:0] wrow, srow;
  always_comb begin
    wfound = 1'b0;
    sfound = 1'b0;
    wrow   = '0;
    srow   = '0;
    for (int r = 0; r < NROWS; r++) begin
      if (!wfound && WHOLE_CODE[r] == code) begin
        wfound = 1'b1;
        wrow   = ROW_W'(r);
      end
      if (!sfound && SPLIT_CODE[r] == code) begin
        sfound = 1'b1;
        srow   = ROW_W'(r);
      end
    end
  end

  logic signed [ANGLE_W-1:0] simple_angle;
  assign simple_angle = ANGLE_W'(ANGLE_W'(STEP[wrow]) * ANGLE_W'(30));

  // numerators of the two interpolated angles
  logic signed [SNW-1:0] tot_s, sa, sb;
  assign tot_s = $signed(SNW'(total));
  assign sa = $signed(SNW'({v[PAD_ONE[row]], 2'b00})) + SNW'(K_ONE[row]) * tot_s;
  assign sb = SNW'(K_TWO[row]) * tot_s - $signed(SNW'({v[PAD_TWO[row]], 2'b00}));

  logic signed [NW-1:0] sa_w, sb_w;
  assign sa_w = NW'(sa);
  assign sb_w = NW'(sb);

  logic                      div_done;
  logic signed [ANGLE_W-1:0] quo;
  ppad_div #(.NW(NW), .DW(TW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start_a | cmd.div_start_b),
    .num   (cmd.div_start_a ? numa : numb),
    .den   (total),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw[0] <= pad_a;
      raw[1] <= pad_b;
      raw[2] <= pad_c;
      raw[3] <= pad_d;
    end
    if (cmd.prep) begin
      for (int i = 0; i < 4; i++) begin
        v[i] <= raw[i] - lo;
      end
      total <= TW'(raw[0] - lo) + TW'(raw[1] - lo) + TW'(raw[2] - lo) + TW'(raw[3] - lo);
    end
    if (cmd.latch_row) begin
      row <= srow;
    end
    if (cmd.calc_num) begin
      numa <= (sa_w <<< 5) - (sa_w <<< 1);
      numb <= (sb_w <<< 5) - (sb_w <<< 1);
    end
    if (cmd.latch_qa) begin
      qa <= quo;
    end
    if (cmd.store_simple) begin
      bk_kind[cnt] <= KIND_SIMPLE;
      bk_a[cnt]    <= simple_angle;
      bk_b[cnt]    <= simple_angle;
      bk_pass[cnt] <= pass;
    end
    if (cmd.store_cplx) begin
      bk_kind[cnt] <= KIND_COMPLEX;
      bk_a[cnt]    <= qa;
      bk_b[cnt]    <= quo;
      bk_pass[cnt] <= pass;
    end
  end

  // search counters
  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= '0;
      pass   <= '0;
      cnt    <= '0;
      idx    <= '0;
    end else begin
      if (cmd.prep) begin
        margin <= '0;
        pass   <= '0;
        cnt    <= '0;
        idx    <= '0;
      end else begin
        if (cmd.pass_adv) begin
          if (pass == 3'(NPASS - 1)) begin
            pass   <= '0;
            margin <= margin + 1'b1;
          end else begin
            pass <= pass + 1'b1;
          end
        end
        if (cmd.store_simple || cmd.store_cplx) begin
          cnt <= cnt + 1'b1;
        end
        if (cmd.emit_step) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  assign stat.at_end     = margin >= limit;
  assign stat.pass_first = pass == '0;
  assign stat.pass_last  = pass == 3'(NPASS - 1);
  assign stat.hit_s      = ncnt == 3'd0 && wfound;
  assign stat.hit_c      = ncnt == 3'd2 && sfound;
  assign stat.cnt_zero   = cnt == '0;
  assign stat.div_done   = div_done;
  assign stat.idx_last   = idx == cnt - 1'b1;

  // result registers
  // by emit time the last pass has already stepped margin one past the hit
  logic signed [ANGLE_W:0] adiff;
  logic [ANGLE_W:0]        aabs;
  logic [MW+14:0]          mext;
  assign adiff = (ANGLE_W + 1)'(bk_a[idx]) - (ANGLE_W + 1)'(bk_b[idx]);
  assign aabs  = adiff[ANGLE_W] ? (ANGLE_W + 1)'(-adiff) : adiff;
  assign mext  = {15'b0, MW'(margin - 1'b1)};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_valid) begin
      if (cmd.out_none) begin
        match_kind   <= KIND_NONE;
        angle_first  <= '0;
        angle_second <= '0;
        spread       <= '0;
        margin_used  <= '0;
        loose_pad    <= '0;
        last         <= 1'b1;
      end else begin
        match_kind   <= bk_kind[idx];
        angle_first  <= bk_a[idx];
        angle_second <= bk_b[idx];
        spread       <= aabs[ANGLE_W-1:0];
        margin_used  <= mext[14:0];
        loose_pad    <= bk_pass[idx];
        last         <= stat.idx_last;
      end
    end
  end

endmodule

`default_nettype wire

### design/ppad_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppad_ctrl
// Sequencer for the margin/pass search, divisions and result beats.
// ----------------------------------------------------------------------------
module ppad_ctrl import ppad_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != ST_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start) state_next = ST_PREP;
      ST_PREP:    state_next = ST_SRCH;
      ST_SRCH: begin
        if (stat.pass_first && stat.at_end) begin
          state_next = ST_NONE;
        end else if (stat.hit_c) begin
          state_next = ST_NUM;
        end else if (stat.pass_last && (!stat.cnt_zero || stat.hit_s)) begin
          state_next = ST_EMIT;
        end
      end
      ST_NUM:     state_next = ST_DA_GO;
      ST_DA_GO:   state_next = ST_DA_WAIT;
      ST_DA_WAIT: if (stat.div_done) state_next = ST_DB_GO;
      ST_DB_GO:   state_next = ST_DB_WAIT;
      ST_DB_WAIT: begin
        if (stat.div_done) begin
          state_next = stat.pass_last ? ST_EMIT : ST_SRCH;
        end
      end
      ST_EMIT:    if (stat.idx_last) state_next = ST_IDLE;
      ST_NONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:  cmd.load = start;
      ST_PREP:  cmd.prep = 1'b1;
      ST_SRCH: begin
        if (!(stat.pass_first && stat.at_end)) begin
          if (stat.hit_c) begin
            cmd.latch_row = 1'b1;
          end else begin
            cmd.store_simple = stat.hit_s;
            cmd.pass_adv     = 1'b1;
          end
        end
      end
      ST_NUM:     cmd.calc_num = 1'b1;
      ST_DA_GO:   cmd.div_start_a = 1'b1;
      ST_DA_WAIT: cmd.latch_qa = stat.div_done;
      ST_DB_GO:   cmd.div_start_b = 1'b1;
      ST_DB_WAIT: begin
        cmd.store_cplx = stat.div_done;
        cmd.pass_adv   = stat.div_done;
      end
      ST_EMIT: begin
        cmd.out_valid = 1'b1;
        cmd.emit_step = !stat.idx_last;
      end
      ST_NONE: begin
        cmd.out_valid = 1'b1;
        cmd.out_none  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/pad_pattern_angle_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: after the accepting edge a prep state, then one search state per pass (5 per
//   margin, margins below total/8), plus two 10-step divisions per complex hit;
//   the buffered result beats are played out after the search.
// Throughput: one item at a time; busy drops in the cycle of the last result beat.
// Results: one beat per cycle, output register, receiver cannot stall.
// Reset: rst synchronous active high, returns to idle, drops result_valid.
// ----------------------------------------------------------------------------
// pad_pattern_angle_decoder
// Four-pad capacitive angle decoder: normalizes the pads, searches a rising
// tolerance margin over five passes each, emits every pattern hit of the
// first margin that has any, or one not-found beat.
// ----------------------------------------------------------------------------
module pad_pattern_angle_decoder import ppad_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [SAMPLE_WIDTH-1:0]  pad_a,
  input  wire logic [SAMPLE_WIDTH-1:0]  pad_b,
  input  wire logic [SAMPLE_WIDTH-1:0]  pad_c,
  input  wire logic [SAMPLE_WIDTH-1:0]  pad_d,
  output logic                          result_valid,
  output logic [1:0]                    match_kind,
  output logic signed [ANGLE_W-1:0]     angle_first,
  output logic signed [ANGLE_W-1:0]     angle_second,
  output logic [ANGLE_W-1:0]            spread,
  output logic [14:0]                   margin_used,
  output logic [2:0]                    loose_pad,
  output logic                          last
);

  // Command and status buses between sequencer and datapath.
  cmd_t  cmd;
  stat_t stat;

  // Sequencer: accepts an item on start while idle, walks margin/pass,
  // runs the two divisions per complex hit, then plays out buffered beats.
  ppad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: hits of one margin are buffered (up to five) so that the
  // final beat can carry last.
  ppad_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .pad_a        (pad_a),
    .pad_b        (pad_b),
    .pad_c        (pad_c),
    .pad_d        (pad_d),
    .result_valid (result_valid),
    .match_kind   (match_kind),
    .angle_first  (angle_first),
    .angle_second (angle_second),
    .spread       (spread),
    .margin_used  (margin_used),
    .loose_pad    (loose_pad),
    .last         (last)
  );

endmodule

`default_nettype wire

### design/ppad_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppad_checker
// Port-level checks of the decoder's result beats.
// ----------------------------------------------------------------------------
module ppad_checker import ppad_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       result_valid,
  input wire logic [1:0] match_kind,
  input wire logic [9:0] angle_first,
  input wire logic [9:0] angle_second,
  input wire logic [9:0] spread,
  input wire logic       last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result beat right after last");

  a_none_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && match_kind == KIND_NONE |-> last && angle_first == '0 && spread == '0)
    else $error("malformed not-found beat");

  a_simple_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && match_kind == KIND_SIMPLE |-> angle_first == angle_second && spread == '0)
    else $error("malformed simple beat");

  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> match_kind != KIND_RSVD)
    else $error("reserved match kind");

endmodule

bind pad_pattern_angle_decoder ppad_checker u_ppad_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .match_kind   (match_kind),
  .angle_first  (angle_first),
  .angle_second (angle_second),
  .spread       (spread),
  .last         (last)
);

`default_nettype wire
